/* rtl/tah_pkg.sv */
// Shared types and constants for the Heron triangle area pipeline.
package tah_pkg;

    localparam int COORD_BITS  = 24;
    localparam int FRAC_BITS   = 12;
    localparam int CORNER_BITS = 4;
    localparam int AREA_BITS   = 37;

    localparam logic [CORNER_BITS-1:0] TRI_CORNERS = CORNER_BITS'(3);
    localparam logic [AREA_BITS-1:0]   AREA_MAX    = {AREA_BITS{1'b1}};

    // Absolute coordinate difference, its square and the sum of three squares.
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int SUM_BITS  = 2 * DIFF_BITS;
    localparam int EDGE_BITS = DIFF_BITS;

    // Heron factors and the split product.
    localparam int F1_BITS   = EDGE_BITS + 2;
    localparam int FS_BITS   = EDGE_BITS + 2;
    localparam int FM_BITS   = EDGE_BITS + 1;
    localparam int CHUNK     = 27;
    localparam int P1_BITS   = F1_BITS + FM_BITS;
    localparam int P2_BITS   = P1_BITS + FM_BITS;
    localparam int P3_BITS   = P2_BITS + FM_BITS;
    localparam int RAD_SHIFT = 2 * FRAC_BITS + 4;

    // Shared square-root pipeline, sized for the final root.
    localparam int SQ_IN_W  = 78;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_OUT_W + 2;

    localparam int IN_BITS    = CORNER_BITS + 9 * COORD_BITS;
    localparam int IN_BYTES_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BYTES_W = ((AREA_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic valid;
        logic not_tri;
    } tag_t;

endpackage

/* rtl/tah_sqrt_pipe.sv */
// Pipelined floor integer square root, one result bit per stage.
module tah_sqrt_pipe
    import tah_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [SQ_IN_W-1:0]  rad_in,
    input  tag_t                tag_in,
    output logic [SQ_OUT_W-1:0] root_out,
    output tag_t                tag_out
);

    logic [SQ_REM_W-1:0] rem_reg  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] root_reg [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  rad_reg  [SQ_OUT_W];
    tag_t                tag_reg  [SQ_OUT_W];

    logic [SQ_REM_W-1:0] rem_next  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] root_next [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  rad_next  [SQ_OUT_W];

    always_comb begin
        logic [SQ_REM_W-1:0] rem_p;
        logic [SQ_OUT_W-1:0] root_p;
        logic [SQ_IN_W-1:0]  rad_p;
        logic [SQ_REM_W-1:0] rem_t;
        logic [SQ_REM_W-1:0] trial;
        for (int k = 0; k < SQ_OUT_W; k++) begin
            if (k == 0) begin
                rem_p  = '0;
                root_p = '0;
                rad_p  = rad_in;
            end else begin
                rem_p  = rem_reg[k-1];
                root_p = root_reg[k-1];
                rad_p  = rad_reg[k-1];
            end
            // The remainder stays below twice the partial root, so its top bits are free.
            rem_t = {rem_p[SQ_REM_W-3:0], rad_p[SQ_IN_W-1 -: 2]};
            trial = {root_p, 2'b01};
            if (rem_t >= trial) begin
                rem_next[k]  = rem_t - trial;
                root_next[k] = {root_p[SQ_OUT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_t;
                root_next[k] = {root_p[SQ_OUT_W-2:0], 1'b0};
            end
            rad_next[k] = {rad_p[SQ_IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_OUT_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SQ_OUT_W; k++) begin
                tag_reg[k] <= '0;
            end
        end else if (en) begin
            tag_reg[0] <= tag_in;
            for (int k = 1; k < SQ_OUT_W; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign root_out = root_reg[SQ_OUT_W-1];
    assign tag_out  = tag_reg[SQ_OUT_W-1];

endmodule

/* rtl/triangle_area_heron_unit.sv */
// Throughput: one triangle per cycle; the whole pipeline advances whenever the
// output register is empty or its result is taken in the same cycle.
// The edge and final square-root pipelines, 39 stages each, set most of the latency.
// Reset (aresetn low, synchronous) clears every valid bit; data registers keep their values.
module triangle_area_heron_unit
    import tah_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // corner_count, ax, ay, az, bx, by_coord, bz, cx, cy, cz; zero pad on top
    input  logic [IN_BYTES_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tri_area; zero pad on top
    output logic [OUT_BYTES_W-1:0] m_tdata,
    // not_triangle
    output logic [0:0]             m_tuser
);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic signed [COORD_BITS-1:0] crd [9];
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            crd[i] = s_tdata[CORNER_BITS + i*COORD_BITS +: COORD_BITS];
        end
    end

    // Stage 1: absolute differences. Edge e runs from corner e to corner (e+1) mod 3.
    logic [DIFF_BITS-1:0] d_reg [9];
    tag_t                 t1_reg;

    always_ff @(posedge aclk) begin
        logic signed [DIFF_BITS-1:0] df;
        if (en) begin
            for (int e = 0; e < 3; e++) begin
                for (int j = 0; j < 3; j++) begin
                    df = DIFF_BITS'(crd[((e+1)%3)*3 + j]) - DIFF_BITS'(crd[e*3 + j]);
                    d_reg[e*3 + j] <= df[DIFF_BITS-1] ? DIFF_BITS'(-df) : DIFF_BITS'(df);
                end
            end
        end
    end

    // Stage 2: squares. Stage 3: sums of squares.
    logic [SQ_BITS-1:0]  sq_reg  [9];
    logic [SUM_BITS-1:0] sum_reg [3];
    tag_t                t2_reg, t3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                sq_reg[i] <= d_reg[i] * d_reg[i];
            end
            for (int e = 0; e < 3; e++) begin
                sum_reg[e] <= sq_reg[e*3] + sq_reg[e*3+1] + sq_reg[e*3+2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end else if (en) begin
            t1_reg.valid   <= s_tvalid;
            t1_reg.not_tri <= s_tdata[CORNER_BITS-1:0] != TRI_CORNERS;
            t2_reg         <= t1_reg;
            t3_reg         <= t2_reg;
        end
    end

    // Edge lengths.
    logic [SQ_OUT_W-1:0] root_e [3];
    tag_t                tag_e  [3];
    tag_t                te;

    for (genvar g = 0; g < 3; g++) begin : g_edge
        tah_sqrt_pipe u_edge_sqrt (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .rad_in   (SQ_IN_W'(sum_reg[g])),
            .tag_in   (t3_reg),
            .root_out (root_e[g]),
            .tag_out  (tag_e[g])
        );
    end

    assign te.valid   = tag_e[0].valid & tag_e[1].valid & tag_e[2].valid;
    assign te.not_tri = tag_e[0].not_tri;

    logic [EDGE_BITS-1:0] ea, eb, ec;
    assign ea = root_e[0][EDGE_BITS-1:0];
    assign eb = root_e[1][EDGE_BITS-1:0];
    assign ec = root_e[2][EDGE_BITS-1:0];

    // Stage 4: Heron factors.
    logic [F1_BITS-1:0]        f1_reg;
    logic signed [FS_BITS-1:0] f2_reg, f3_reg, f4_reg;
    tag_t                      t4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= F1_BITS'(ea) + F1_BITS'(eb) + F1_BITS'(ec);
            f2_reg <= FS_BITS'(eb) + FS_BITS'(ec) - FS_BITS'(ea);
            f3_reg <= FS_BITS'(ea) + FS_BITS'(ec) - FS_BITS'(eb);
            f4_reg <= FS_BITS'(ea) + FS_BITS'(eb) - FS_BITS'(ec);
        end
    end

    logic neg4;
    assign neg4 = (f2_reg <= 0) || (f3_reg <= 0) || (f4_reg <= 0);

    // Stages 5 to 9: the product, with wide operands split into pieces at 27-bit boundaries.
    logic [P1_BITS-1:0]      p1_reg;
    logic [FM_BITS-1:0]      f3a_reg, f4a_reg, f4b_reg, f4c_reg;
    logic [P1_BITS-1:0]      lo6_reg;
    logic [P1_BITS-2:0]      hi6_reg;
    logic [P2_BITS-1:0]      p2_reg;
    logic [P1_BITS-1:0]      c0_reg, c1_reg;
    logic [P2_BITS-CHUNK*2+FM_BITS-1:0] c2_reg;
    logic [SQ_IN_W-1:0]      rad_reg;
    logic                    n5_reg, n6_reg, n7_reg, n8_reg;
    tag_t                    t5_reg, t6_reg, t7_reg, t8_reg, t9_reg;

    logic [P3_BITS-1:0] p3_next;
    assign p3_next = P3_BITS'(c0_reg) + (P3_BITS'(c1_reg) << CHUNK)
                   + (P3_BITS'(c2_reg) << (2*CHUNK));

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= f1_reg * f2_reg[FM_BITS-1:0];
            f3a_reg <= f3_reg[FM_BITS-1:0];
            f4a_reg <= f4_reg[FM_BITS-1:0];
            n5_reg  <= neg4;

            lo6_reg <= p1_reg[CHUNK-1:0] * f3a_reg;
            hi6_reg <= p1_reg[P1_BITS-1:CHUNK] * f3a_reg;
            f4b_reg <= f4a_reg;
            n6_reg  <= n5_reg;

            p2_reg  <= P2_BITS'(lo6_reg) + (P2_BITS'(hi6_reg) << CHUNK);
            f4c_reg <= f4b_reg;
            n7_reg  <= n6_reg;

            c0_reg  <= p2_reg[CHUNK-1:0] * f4c_reg;
            c1_reg  <= p2_reg[2*CHUNK-1:CHUNK] * f4c_reg;
            c2_reg  <= p2_reg[P2_BITS-1:2*CHUNK] * f4c_reg;
            n8_reg  <= n7_reg;

            // A broken triangle inequality gives a zero radicand and so a zero area.
            rad_reg <= n8_reg ? '0 : SQ_IN_W'(p3_next[P3_BITS-1:RAD_SHIFT]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t4_reg <= '0;
            t5_reg <= '0;
            t6_reg <= '0;
            t7_reg <= '0;
            t8_reg <= '0;
            t9_reg <= '0;
        end else if (en) begin
            t4_reg <= te;
            t5_reg <= t4_reg;
            t6_reg <= t5_reg;
            t7_reg <= t6_reg;
            t8_reg <= t7_reg;
            t9_reg <= t8_reg;
        end
    end

    // Final square root and output register.
    logic [SQ_OUT_W-1:0] root_f;
    tag_t                tag_f;

    tah_sqrt_pipe u_area_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .rad_in   (rad_reg),
        .tag_in   (t9_reg),
        .root_out (root_f),
        .tag_out  (tag_f)
    );

    logic [AREA_BITS-1:0] area_next;
    always_comb begin
        if (tag_f.not_tri || (root_f > SQ_OUT_W'(AREA_MAX))) begin
            area_next = AREA_MAX;
        end else begin
            area_next = root_f[AREA_BITS-1:0];
        end
    end

    logic [AREA_BITS-1:0] area_reg;
    logic                 not_tri_reg;
    logic                 out_valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            area_reg    <= area_next;
            not_tri_reg <= tag_f.not_tri;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= tag_f.valid;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = OUT_BYTES_W'(area_reg);
    assign m_tuser[0] = not_tri_reg;

endmodule

/* rtl/tah_checker.sv */
// Port-level assertions for the Heron triangle area unit, bound to the top level.
module tah_checker
    import tah_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_BYTES_W-1:0] m_tdata,
    input logic [0:0]             m_tuser
);

    // A face that is not a triangle always reports the all-ones area.
    a_not_tri_area: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[AREA_BITS-1:0] == AREA_MAX))
        else $error("non-triangle result without all-ones area");

    // The input side stalls exactly when a result is held back.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // Nothing comes out right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind triangle_area_heron_unit tah_checker u_tah_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/triangle_area_heron_unit_tb.sv */
// Self-checking testbench for the Heron triangle area unit, with stall and idle phases.
module triangle_area_heron_unit_tb;
    import tah_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 1950;

    typedef struct packed {
        logic [AREA_BITS-1:0] area;
        logic                 not_tri;
    } area_result_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Floor square root of a value of up to 128 bits.
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int bit_idx = 63; bit_idx >= 0; bit_idx--) begin
            c = r | (64'd1 << bit_idx);
            if (128'(c) * 128'(c) <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] edge_length(input coord_t u[3], input coord_t v[3]);
        logic [127:0] sum;
        longint       d;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            d = longint'(u[i]) - longint'(v[i]);
            if (d < 0) begin
                d = -d;
            end
            sum += 128'(d) * 128'(d);
        end
        return floor_sqrt(sum);
    endfunction

    function automatic area_result_t heron_area(input logic [IN_BYTES_W-1:0] item);
        area_result_t res;
        coord_t       pa[3];
        coord_t       pb[3];
        coord_t       pc[3];
        longint       a;
        longint       b;
        longint       c;
        longint       f2;
        longint       f3;
        longint       f4;
        logic [255:0] prod;
        res.not_tri = 1'b0;
        if (item[CORNER_BITS-1:0] != TRI_CORNERS) begin
            res.area    = AREA_MAX;
            res.not_tri = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            pa[i] = item[CORNER_BITS + i*COORD_BITS +: COORD_BITS];
            pb[i] = item[CORNER_BITS + (3+i)*COORD_BITS +: COORD_BITS];
            pc[i] = item[CORNER_BITS + (6+i)*COORD_BITS +: COORD_BITS];
        end
        a  = longint'(edge_length(pa, pb));
        b  = longint'(edge_length(pb, pc));
        c  = longint'(edge_length(pc, pa));
        f2 = b + c - a;
        f3 = a + c - b;
        f4 = a + b - c;
        if (f2 <= 0 || f3 <= 0 || f4 <= 0) begin
            res.area = '0;
        end else begin
            prod = 256'(a + b + c) * 256'(f2) * 256'(f3) * 256'(f4);
            if (prod[255:128] != 0) begin
                res.area = AREA_MAX;
            end else begin
                prod = prod >> RAD_SHIFT;
                prod[63:0] = floor_sqrt(prod[127:0]);
                res.area = (prod[63:0] > 64'(AREA_MAX)) ? AREA_MAX : prod[AREA_BITS-1:0];
            end
        end
        return res;
    endfunction

    class area_scoreboard;
        area_result_t pending[$];
        int           errors;

        function void note_input(logic [IN_BYTES_W-1:0] item);
            pending = {pending, heron_area(item)};
        endfunction

        function void check_result(logic [OUT_BYTES_W-1:0] tdata, logic tuser);
            area_result_t exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result area=%0d flag=%0d",
                         $realtime, tdata[AREA_BITS-1:0], tuser);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (tdata != OUT_BYTES_W'(exp_res.area)) begin
                $display("%0t: tri_area expected %0d actual %0d",
                         $realtime, exp_res.area, tdata);
                errors++;
            end
            if (tuser != exp_res.not_tri) begin
                $display("%0t: not_triangle expected %0d actual %0d",
                         $realtime, exp_res.not_tri, tuser);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_BYTES_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic [0:0]             m_tuser;

    area_scoreboard board;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             quiet_cycles = 0;

    triangle_area_heron_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Check results and count cycles without any transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata, m_tuser[0]);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic coord_t random_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(8191) - 4096);
            2: return coord_t'($urandom_range(1048575) - 524288);
            default: return ($urandom_range(1)) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
        endcase
    endfunction

    function automatic logic [IN_BYTES_W-1:0] pack_item(input logic [3:0] corners,
                                                        input coord_t pts[9]);
        logic [IN_BYTES_W-1:0] item;
        item = '0;
        item[CORNER_BITS-1:0] = corners;
        for (int i = 0; i < 9; i++) begin
            item[CORNER_BITS + i*COORD_BITS +: COORD_BITS] = pts[i];
        end
        return item;
    endfunction

    // Leaves s_tvalid high after the transfer; the next call or the caller lowers it.
    task automatic send_item(input logic [IN_BYTES_W-1:0] item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        board.note_input(item);
        @(negedge aclk);
    endtask

    task automatic send_random_item();
        coord_t     pts[9];
        int         mode;
        logic [3:0] corners;
        mode = $urandom_range(3);
        corners = ($urandom_range(9) == 0) ? 4'($urandom) : TRI_CORNERS;
        for (int i = 0; i < 9; i++) begin
            pts[i] = random_coord(($urandom_range(9) == 0) ? $urandom_range(3) : mode);
        end
        // Occasionally make corners coincide or lie on one line.
        case ($urandom_range(9))
            0: for (int i = 0; i < 3; i++) pts[3+i] = pts[i];
            1: for (int i = 0; i < 3; i++) pts[6+i] = coord_t'(2*pts[3+i] - pts[i]);
            default: ;
        endcase
        send_item(pack_item(corners, pts));
    endtask

    task automatic send_directed();
        coord_t pts[9];
        coord_t mx;
        coord_t mn;
        mx = 24'h7fffff;
        mn = 24'h800000;
        for (int n = 0; n < 16; n += 5) begin
            pts = '{default: coord_t'(n * 1000)};
            pts[3] = 24'sd4096;
            pts[7] = 24'sd8192;
            send_item(pack_item(4'(n), pts));
        end
        pts = '{0, 0, 0, 12288, 0, 0, 0, 16384, 0};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{default: mx};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{mn, mn, mn, mx, mx, mn, mn, mx, mx};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{mx, mx, mx, mn, mn, mx, mx, mn, mn};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{0, 0, 0, 3, 0, 0, 7, 1, 0};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{-1, -1, -1, mx, 0, mn, 5, mx, -7};
        send_item(pack_item(TRI_CORNERS, pts));
        pts = '{24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555,
                24'haaaaaa, 24'h123456, 24'hedcba9, 0};
        send_item(pack_item(4'hf, pts));
        send_item(pack_item(TRI_CORNERS, pts));
    endtask

    initial begin
        int idle_modes[4][2];
        board          = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_modes     = '{'{0, 0}, '{71, 0}, '{0, 71}, '{24, 24}};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_directed();
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_modes[phase][0];
            recv_stall_pct = idle_modes[phase][1];
            for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
                send_random_item();
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (board.pending.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
